>>> hdl/slut_pkg.sv
// ----------------------------------------------------------------------------
// slut_pkg: shared types for the subscription lookup table
// Holds the opcode and state encodings, the stored entry layout and the
// command/status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package slut_pkg;

    localparam int unsigned CLIENT_W   = 32;
    localparam int unsigned FUNCTION_W = 16;
    localparam int unsigned REQUEST_W  = 16;
    localparam int unsigned OPCODE_W   = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_REGISTER   = 2'd0,
        OP_DEACTIVATE = 2'd1,
        OP_QUERY      = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic [CLIENT_W-1:0]   client;
        logic [FUNCTION_W-1:0] func;
        logic [REQUEST_W-1:0]  request;
        logic                  active;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the item, restart the scan
        logic scan;   // walk the filled entries
        logic apply;  // write back and produce the answer
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;        // compared entry matches the key
        logic exhausted;  // every filled entry compared, no match
    } status_t;

endpackage

>>> hdl/subscription_lookup_table_unit.sv
// ----------------------------------------------------------------------------
// subscription_lookup_table_unit: associative subscription table
// Register, deactivate or query entries keyed by client id and function id.
// ----------------------------------------------------------------------------
// Flow: an accepted item is captured, the filled entries are scanned until a hit
// or until all are compared, then the write-back raises the registered done strobe.
// busy stays high through the scan and the write-back and the next item is
// taken at the edge that ends the done strobe, so a new item is not taken before
// the last is through; the scan reads the entry memory one entry per cycle.
// Reset: rst_n clears fill count and control, no clearing pass; no stall.
module subscription_lookup_table_unit
#(
    parameter int unsigned TABLE_DEPTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [slut_pkg::OPCODE_W-1:0]       opcode,
    input  logic [slut_pkg::CLIENT_W-1:0]       client_id,
    input  logic [slut_pkg::FUNCTION_W-1:0]     function_id,
    input  logic [slut_pkg::REQUEST_W-1:0]      request_id,
    output logic                                done,
    output logic                                answer
);
    import slut_pkg::*;

    cmd_t    cmd;
    status_t st;

    // sequence each item: capture, scan, write back
    slut_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    // hold the table and walk it one entry per cycle
    slut_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .opcode      (opcode),
        .client_id   (client_id),
        .function_id (function_id),
        .request_id  (request_id),
        .done        (done),
        .answer      (answer)
    );

endmodule

>>> hdl/slut_ctrl.sv
// ----------------------------------------------------------------------------
// slut_ctrl: operation sequencer
// Steps each item through capture, table scan and write-back.
// ----------------------------------------------------------------------------
module slut_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  slut_pkg::status_t st,
    output slut_pkg::cmd_t    cmd,
    output logic              busy
);
    import slut_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.hit || st.exhausted)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_apply_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY) |=> (state_reg == ST_IDLE))
        else $error("write-back lasted more than one cycle");
    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_SCAN))
        else $error("accepted item did not enter the scan");
`endif

endmodule

>>> hdl/slut_dpath.sv
// ----------------------------------------------------------------------------
// slut_dpath: table storage and scan datapath
// Holds the entry memory and fill count, compares one entry per cycle
// against the captured key and performs the write-back.
// ----------------------------------------------------------------------------
module slut_dpath
#(
    parameter int unsigned TABLE_DEPTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  slut_pkg::cmd_t                      cmd,
    output slut_pkg::status_t                   st,
    input  logic [slut_pkg::OPCODE_W-1:0]       opcode,
    input  logic [slut_pkg::CLIENT_W-1:0]       client_id,
    input  logic [slut_pkg::FUNCTION_W-1:0]     function_id,
    input  logic [slut_pkg::REQUEST_W-1:0]      request_id,
    output logic                                done,
    output logic                                answer
);
    import slut_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    entry_t mem [TABLE_DEPTH];

    op_t                   op_reg;
    logic [CLIENT_W-1:0]   cid_reg;
    logic [FUNCTION_W-1:0] fid_reg;
    logic [REQUEST_W-1:0]  rid_reg;

    logic [CW-1:0] fill_reg;
    logic [CW-1:0] rd_ptr_reg;
    logic [IW-1:0] cmp_ptr_reg;
    logic          cmp_valid_reg;
    entry_t        rd_data_reg;

    logic          found_reg;
    logic [IW-1:0] hit_idx_reg;
    entry_t        hit_entry_reg;

    logic          done_reg;
    logic          answer_reg;

    logic          issue;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    logic          fill_inc;
    logic          ans;

    assign issue = cmd.scan && (rd_ptr_reg < fill_reg);

    assign st.hit = cmp_valid_reg && (rd_data_reg.client == cid_reg)
                    && (rd_data_reg.func == fid_reg);
    assign st.exhausted = !cmp_valid_reg && (rd_ptr_reg >= fill_reg);

    // capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(opcode);
            cid_reg <= client_id;
            fid_reg <= function_id;
            rid_reg <= request_id;
        end
    end

    // scan pointers: read entry n while comparing entry n-1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else if (cmd.load)
        begin
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_valid_reg <= issue;
            if (issue)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (st.hit)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cmp_ptr_reg <= rd_ptr_reg[IW-1:0];
        end
        if (cmd.scan && st.hit)
        begin
            hit_idx_reg   <= cmp_ptr_reg;
            hit_entry_reg <= rd_data_reg;
        end
    end

    // entry memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[rd_ptr_reg[IW-1:0]];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-back and answer
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = hit_idx_reg;
        wr_data  = '{client: cid_reg, func: fid_reg, request: rid_reg, active: 1'b1};
        fill_inc = 1'b0;
        ans      = 1'b0;
        case (op_reg)
            OP_REGISTER:
            begin
                if (found_reg)
                begin
                    wr_en = cmd.apply;
                    ans   = 1'b1;
                end
                else if (fill_reg < DEPTH_C)
                begin
                    wr_en    = cmd.apply;
                    wr_addr  = fill_reg[IW-1:0];
                    fill_inc = cmd.apply;
                    ans      = 1'b1;
                end
            end
            OP_DEACTIVATE:
            begin
                if (found_reg)
                begin
                    wr_en          = cmd.apply;
                    wr_data        = hit_entry_reg;
                    wr_data.active = 1'b0;
                    ans            = 1'b1;
                end
            end
            OP_QUERY:
            begin
                ans = found_reg && hit_entry_reg.active;
            end
            default:
            begin
                ans = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.apply;
            if (fill_inc)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            answer_reg <= ans;
        end
    end

    assign done   = done_reg;
    assign answer = answer_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("fill count beyond table depth");
    a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");
`endif

endmodule

>>> dv/subscription_lookup_table_unit_test.sv
// ----------------------------------------------------------------------------
// subscription_lookup_table_unit_test: self-checking bench for the lookup table
// Drives register, deactivate, query and unused-opcode items over the command
// handshake, predicts every answer with a local copy of the table and checks
// each done strobe against the oldest predicted answer.
// ----------------------------------------------------------------------------
module subscription_lookup_table_unit_test;

    import slut_pkg::*;

    localparam int unsigned TABLE_DEPTH = 32;
    // Key pool larger than the table so that it fills and then refuses.
    localparam int          KEY_POOL    = 44;
    localparam int          RANDOM_CMDS = 1800;
    localparam int          QUIET_LIMIT = 5000;
    localparam int          SETTLE_CYCS = TABLE_DEPTH + 8;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OPCODE_W-1:0]   opcode;
        logic [CLIENT_W-1:0]   client;
        logic [FUNCTION_W-1:0] func;
        logic [REQUEST_W-1:0]  request;
        int                    idle_pct;     // chance of a sender gap per cycle
        bit                    drain_first;  // hold off until all answers are in
    } table_cmd_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [OPCODE_W-1:0]   opcode = '0;
    logic [CLIENT_W-1:0]   client_id = '0;
    logic [FUNCTION_W-1:0] function_id = '0;
    logic [REQUEST_W-1:0]  request_id = '0;
    logic                  busy;
    logic                  done;
    logic                  answer;

    subscription_lookup_table_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .client_id   (client_id),
        .function_id (function_id),
        .request_id  (request_id),
        .done        (done),
        .answer      (answer)
    );

    // ------------------------------------------------------------------
    // Local copy of the table contents
    // ------------------------------------------------------------------
    logic [CLIENT_W-1:0]   tbl_client  [TABLE_DEPTH];
    logic [FUNCTION_W-1:0] tbl_func    [TABLE_DEPTH];
    logic [REQUEST_W-1:0]  tbl_request [TABLE_DEPTH];
    bit                    tbl_active  [TABLE_DEPTH];
    int                    tbl_fill = 0;

    // Key pool used to produce hits; some keys share one half with a neighbor
    logic [CLIENT_W-1:0]   pool_client [KEY_POOL];
    logic [FUNCTION_W-1:0] pool_func   [KEY_POOL];

    table_cmd_t pending_cmds[$];
    bit         answer_expected_q[$];

    int total_cmds     = 0;
    int driven_count   = 0;
    int accepted_count = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;
    int op_seen [4]    = '{0, 0, 0, 0};
    int full_refusals  = 0;
    int hit_answers    = 0;

    // Apply one item to the local table and return the answer it must give.
    // Only entries below the fill count are ever compared, so entries that
    // were never written are never read.
    function automatic bit apply_to_table(input logic [OPCODE_W-1:0]   op,
                                          input logic [CLIENT_W-1:0]   cid,
                                          input logic [FUNCTION_W-1:0] fid,
                                          input logic [REQUEST_W-1:0]  rid);
        int hit_idx;
        bit result;
        hit_idx = -1;
        result  = 1'b0;
        for (int i = 0; i < tbl_fill; i++)
        begin
            if (hit_idx < 0 && tbl_client[i] == cid && tbl_func[i] == fid)
                hit_idx = i;
        end
        case (op)
            OP_REGISTER:
            begin
                if (hit_idx >= 0)
                begin
                    // update in place and reactivate
                    tbl_request[hit_idx] = rid;
                    tbl_active[hit_idx]  = 1'b1;
                    result = 1'b1;
                end
                else if (tbl_fill < TABLE_DEPTH)
                begin
                    // append a fresh active entry
                    tbl_client[tbl_fill]  = cid;
                    tbl_func[tbl_fill]    = fid;
                    tbl_request[tbl_fill] = rid;
                    tbl_active[tbl_fill]  = 1'b1;
                    tbl_fill++;
                    result = 1'b1;
                end
                // table full: nothing changes, refuse
            end
            OP_DEACTIVATE:
            begin
                if (hit_idx >= 0)
                begin
                    tbl_active[hit_idx] = 1'b0;
                    result = 1'b1;
                end
            end
            OP_QUERY:
            begin
                if (hit_idx >= 0)
                    result = tbl_active[hit_idx];
            end
            default:
                result = 1'b0;  // unused opcode does nothing
        endcase
        return result;
    endfunction

    function automatic table_cmd_t random_cmd(input int idle_pct);
        table_cmd_t c;
        int         pick;
        int         k;
        pick = $urandom_range(99);
        if (pick < 35)
            c.opcode = OP_REGISTER;
        else if (pick < 55)
            c.opcode = OP_DEACTIVATE;
        else if (pick < 92)
            c.opcode = OP_QUERY;
        else
            c.opcode = OP_UNUSED;
        if ($urandom_range(99) < 82)
        begin
            k        = $urandom_range(KEY_POOL - 1);
            c.client = pool_client[k];
            c.func   = pool_func[k];
        end
        else
        begin
            // fully random key, almost always a miss
            c.client = $urandom;
            c.func   = FUNCTION_W'($urandom);
        end
        c.request     = REQUEST_W'($urandom);
        c.idle_pct    = idle_pct;
        c.drain_first = ($urandom_range(99) < 2);
        return c;
    endfunction

    task automatic add_cmd(input logic [OPCODE_W-1:0]   op,
                           input logic [CLIENT_W-1:0]   cid,
                           input logic [FUNCTION_W-1:0] fid,
                           input logic [REQUEST_W-1:0]  rid);
        table_cmd_t c;
        c.opcode      = op;
        c.client      = cid;
        c.func        = fid;
        c.request     = rid;
        c.idle_pct    = 0;
        c.drain_first = 1'b0;
        pending_cmds.push_back(c);
        total_cmds++;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge. Hold an item on the ports
    // until the rising edge that takes it, then advance to the next one.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && !(start && accepted_count == driven_count - 1))
        begin
            if (pending_cmds.size() == 0
                || (pending_cmds[0].drain_first && answer_expected_q.size() != 0)
                || $urandom_range(99) < pending_cmds[0].idle_pct)
            begin
                // idle cycle: drop start and scramble the payload
                start       <= 1'b0;
                opcode      <= OPCODE_W'($urandom);
                client_id   <= $urandom;
                function_id <= FUNCTION_W'($urandom);
                request_id  <= REQUEST_W'($urandom);
            end
            else
            begin
                start       <= 1'b1;
                opcode      <= pending_cmds[0].opcode;
                client_id   <= pending_cmds[0].client;
                function_id <= pending_cmds[0].func;
                request_id  <= pending_cmds[0].request;
                void'(pending_cmds.pop_front());
                driven_count <= driven_count + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge. Check the answer strobe against
    // the oldest prediction first, then predict for a newly taken item.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit want;
        bit took;
        if (rst_n)
        begin
            took = start && !busy;
            if (done)
            begin
                if (answer_expected_q.size() == 0)
                begin
                    $error("answer strobe with no item outstanding: actual %0d", answer);
                    error_count++;
                end
                else
                begin
                    want = answer_expected_q.pop_front();
                    if (answer !== want)
                    begin
                        $error("answer mismatch: expected %0d, actual %0d", want, answer);
                        error_count++;
                    end
                end
            end
            if (took)
            begin
                want = apply_to_table(opcode, client_id, function_id, request_id);
                answer_expected_q.push_back(want);
                op_seen[opcode]++;
                if (opcode == OP_REGISTER && !want)
                    full_refusals++;
                if (want)
                    hit_answers++;
                accepted_count <= accepted_count + 1;
            end
            // Watchdog: count cycles with no handshake and no answer
            if (took || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int idle_pct;
        table_cmd_t c;

        for (int k = 0; k < KEY_POOL; k++)
        begin
            pool_client[k] = (k % 3 == 1) ? pool_client[k-1] : $urandom;
            pool_func[k]   = (k % 5 == 2) ? pool_func[k-1] : FUNCTION_W'($urandom);
        end

        // Directed part: empty-table misses, extreme keys, update in place,
        // deactivate twice, half-matching keys and the unused opcode.
        add_cmd(OP_QUERY,      32'h0000_0000, 16'h0000, 16'h0000);
        add_cmd(OP_DEACTIVATE, 32'h0000_0000, 16'h0000, 16'hFFFF);
        add_cmd(OP_UNUSED,     32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        add_cmd(OP_REGISTER,   32'h0000_0000, 16'h0000, 16'h0000);
        add_cmd(OP_REGISTER,   32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        add_cmd(OP_QUERY,      32'h0000_0000, 16'h0000, 16'h1234);
        add_cmd(OP_DEACTIVATE, 32'h0000_0000, 16'h0000, 16'h0000);
        add_cmd(OP_QUERY,      32'h0000_0000, 16'h0000, 16'h0000);
        add_cmd(OP_DEACTIVATE, 32'h0000_0000, 16'h0000, 16'h0000);
        add_cmd(OP_REGISTER,   32'h0000_0000, 16'h0000, 16'hA5A5);
        add_cmd(OP_QUERY,      32'h0000_0000, 16'h0000, 16'h0000);
        add_cmd(OP_QUERY,      32'hFFFF_FFFF, 16'h0000, 16'h0000);
        add_cmd(OP_QUERY,      32'h0000_0000, 16'hFFFF, 16'h0000);
        add_cmd(OP_UNUSED,     32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
        add_cmd(OP_QUERY,      32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
        add_cmd(OP_REGISTER,   32'hFFFF_FFFF, 16'h0000, 16'h5A5A);
        add_cmd(OP_DEACTIVATE, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
        add_cmd(OP_QUERY,      32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        add_cmd(OP_QUERY,      32'hFFFF_FFFF, 16'h0000, 16'h0000);

        // Random part in four phases of sender idling: none, heavy, none, light.
        // The first item of each phase waits for every answer to come back.
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            case (n / (RANDOM_CMDS / 4))
                1:       idle_pct = 50;
                3:       idle_pct = 22;
                default: idle_pct = 0;
            endcase
            c = random_cmd(idle_pct);
            if (n % (RANDOM_CMDS / 4) == 0)
                c.drain_first = 1'b1;
            pending_cmds.push_back(c);
            total_cmds++;
        end

        // Hold reset, then release it at a falling edge, between rising edges
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_count != total_cmds || answer_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCS) @(posedge clk);

        $display("Ran %0d items: %0d register, %0d deactivate, %0d query, %0d unused opcode",
                 accepted_count, op_seen[OP_REGISTER], op_seen[OP_DEACTIVATE],
                 op_seen[OP_QUERY], op_seen[OP_UNUSED]);
        $display("Table filled to %0d of %0d entries, %0d registers refused, %0d true answers",
                 tbl_fill, TABLE_DEPTH, full_refusals, hit_answers);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> subscription_lookup_table_unit.f
hdl/slut_pkg.sv
hdl/slut_ctrl.sv
hdl/slut_dpath.sv
hdl/subscription_lookup_table_unit.sv
dv/subscription_lookup_table_unit_test.sv
